/* rtl/core/dsme_pkg.sv */
// Package with shared types and constants for the measurement extend block.
`timescale 1ns / 1ps
package dsme_pkg;

    typedef logic [255:0] t_word256;

    typedef enum logic [1:0] {
        OUTCOME_ADDED    = 2'd0,
        OUTCOME_PRESENT  = 2'd1,
        OUTCOME_REJECTED = 2'd2
    } t_outcome;

    localparam int unsigned NUM_REGS = 8;

    typedef enum logic [2:0] {
        REG_HOST_0 = 3'd0,
        REG_HOST_1 = 3'd1,
        REG_HOST_2 = 3'd2,
        REG_HOST_3 = 3'd3,
        REG_AGG_0  = 3'd4,
        REG_AGG_1  = 3'd5,
        REG_AGG_2  = 3'd6,
        REG_AGG_3  = 3'd7
    } t_reg_index;

    // Work handed from the front to the back: the point and what to do with it.
    typedef struct packed {
        t_word256 point;
        logic     do_aggregate;
        logic     do_extend;
        t_outcome outcome;
    } t_job;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Padding block for a 64-byte message.
    localparam logic [511:0] PAD_BLOCK = {32'h80000000, 448'd0, 32'd512};

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/dedup_sha256_measurement_extend.sv */
// Top level of the deduplicating SHA-256 measurement extend block.
`timescale 1ns / 1ps
// Usage: an input word (i_point_word_0..3) is accepted when i_valid and o_ready
// are both high. Each input word produces exactly one output word on
// o_valid/i_ready carrying o_outcome and the measurement o_digest_word_0..3.
// Host identity and aggregate registers must be written through the APB port at
// byte address 8*i only while the block is idle; the block itself does not
// enforce this; reads return the value. The front end walks the point store,
// reading and comparing each stored point, then passes a job through a two-entry
// queue to the back end. The back end runs SHA-256 compressions on a single
// round-per-cycle core: four compressions per new point, four more on the first
// word for the aggregate. The front end can classify the next word while the
// back end is still hashing.
// Reset (synchronous, active low) zeroes the measurement, count, flags and
// registers. The point store needs no clearing: only written entries are read.
// When the receiver stalls, the result holds in the back end, the queue fills
// and then the front end stops taking input words.
module dedup_sha256_measurement_extend #(
    parameter int MAX_POINTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_point_word_0,
    input  logic [63:0] i_point_word_1,
    input  logic [63:0] i_point_word_2,
    input  logic [63:0] i_point_word_3,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_outcome,
    output logic [63:0] o_digest_word_0,
    output logic [63:0] o_digest_word_1,
    output logic [63:0] o_digest_word_2,
    output logic [63:0] o_digest_word_3,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] r_regs [dsme_pkg::NUM_REGS];
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign prdata  = r_regs[reg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dsme_pkg::NUM_REGS; i++) r_regs[i] <= '0;
        end else if (psel && penable && pwrite) begin
            r_regs[reg_idx] <= pwdata;
        end
    end

    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    dsme_pkg::t_job fq_job, qb_job;
    logic [255:0]   digest;

    dsme_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_point     ({i_point_word_0, i_point_word_1, i_point_word_2, i_point_word_3}),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    dsme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_job   (fq_job),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_job   (qb_job)
    );

    dsme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (qb_valid),
        .o_ready     (qb_ready),
        .i_job       (qb_job),
        .i_host      ({r_regs[dsme_pkg::REG_HOST_0], r_regs[dsme_pkg::REG_HOST_1],
                       r_regs[dsme_pkg::REG_HOST_2], r_regs[dsme_pkg::REG_HOST_3]}),
        .i_aggregate ({r_regs[dsme_pkg::REG_AGG_0], r_regs[dsme_pkg::REG_AGG_1],
                       r_regs[dsme_pkg::REG_AGG_2], r_regs[dsme_pkg::REG_AGG_3]}),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_outcome   (o_outcome),
        .o_digest    (digest)
    );

    assign o_digest_word_0 = digest[255:192];
    assign o_digest_word_1 = digest[191:128];
    assign o_digest_word_2 = digest[127:64];
    assign o_digest_word_3 = digest[63:0];

endmodule

/* rtl/core/dsme_sha_core.sv */
// One SHA-256 compression, one round per cycle.
`timescale 1ns / 1ps
module dsme_sha_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_h,
    input  logic [511:0] i_block,
    output logic         o_done,
    output logic [255:0] o_h
);

    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [255:0] r_h;
    logic [5:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [31:0] n_wnew, s0w, s1w, s0, s1, ch, maj, t1, t2;

    always_comb begin
        s0w = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1w = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
            ^ (r_w[14] >> 10);
        n_wnew = r_w[0] + s0w + r_w[9] + s1w;
        s1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
           ^ {r_v[4][24:0], r_v[4][31:25]};
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + dsme_pkg::round_k(r_round) + r_w[0];
        s0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
           ^ {r_v[0][21:0], r_v[0][31:22]};
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                r_h     <= i_h;
                for (int i = 0; i < 16; i++) begin
                    r_w[i] <= i_block[511 - 32*i -: 32];
                end
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= i_h[255 - 32*i -: 32];
                end
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= n_wnew;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_h[255 - 32*i -: 32] = r_h[255 - 32*i -: 32] + r_v[i];
        end
    end
    assign o_done = r_done;

endmodule

/* rtl/core/dsme_front.sv */
// Front end: point store lookup, append and poison decision.
`timescale 1ns / 1ps
module dsme_front #(
    parameter int MAX_POINTS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [255:0]    i_point,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output dsme_pkg::t_job  o_job
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_EMIT} t_state;

    logic [255:0]   r_mem [MAX_POINTS];
    logic [255:0]   r_rd;
    logic [255:0]   r_point;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic           r_poison;
    logic           r_agg_done;
    t_state         r_state;
    dsme_pkg::t_job r_job;
    logic           r_wr;

    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            r_mem[r_count[AW-1:0]] <= r_point;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_poison   <= 1'b0;
            r_agg_done <= 1'b0;
            r_wr       <= 1'b0;
        end else begin
            r_wr <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_point <= i_point;
                        r_idx   <= '0;
                        r_job.point        <= i_point;
                        r_job.do_aggregate <= !r_poison && !r_agg_done;
                        r_job.do_extend    <= 1'b0;
                        if (r_poison) begin
                            r_job.outcome <= dsme_pkg::OUTCOME_REJECTED;
                            r_state <= S_EMIT;
                        end else begin
                            r_agg_done <= 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_idx == r_count) begin
                        if (r_count == CW'(MAX_POINTS)) begin
                            r_poison <= 1'b1;
                            r_job.outcome <= dsme_pkg::OUTCOME_REJECTED;
                        end else begin
                            r_wr <= 1'b1;
                            r_job.do_extend <= 1'b1;
                            r_job.outcome <= dsme_pkg::OUTCOME_ADDED;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_rd == r_point) begin
                        r_job.outcome <= dsme_pkg::OUTCOME_PRESENT;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_EMIT: begin
                    if (r_wr) begin
                        r_count <= r_count + 1'b1;
                    end
                    // The job is offered only once the store write has gone in.
                    if (i_job_ready && !r_wr) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_EMIT) && !r_wr;
    assign o_job       = r_job;

endmodule

/* rtl/core/dsme_queue.sv */
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module dsme_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dsme_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output dsme_pkg::t_job o_job
);

    dsme_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/core/dsme_back.sv */
// Back end: runs the extends for a job and holds the result word.
`timescale 1ns / 1ps
module dsme_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dsme_pkg::t_job i_job,
    input  logic [255:0]   i_host,
    input  logic [255:0]   i_aggregate,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_outcome,
    output logic [255:0]   o_digest
);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_C1, S_C2, S_C3, S_C4, S_OUT} t_state;

    t_state         r_state;
    dsme_pkg::t_job r_job;
    logic [255:0]   r_digest;
    logic           r_start;
    logic [255:0]   r_h_in;
    logic [511:0]   r_blk;
    logic           core_done;
    logic [255:0]   core_h;

    dsme_sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_h     (r_h_in),
        .i_block (r_blk),
        .o_done  (core_done),
        .o_h     (core_h)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_digest <= '0;
            r_start  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Pick the next value to extend, aggregate first.
                    if (r_job.do_aggregate) begin
                        r_job.do_aggregate <= 1'b0;
                        r_h_in  <= dsme_pkg::INIT_H;
                        r_blk   <= {i_host, i_aggregate};
                        r_start <= 1'b1;
                        r_state <= S_C1;
                    end else if (r_job.do_extend) begin
                        r_job.do_extend <= 1'b0;
                        r_h_in  <= dsme_pkg::INIT_H;
                        r_blk   <= {i_host, r_job.point};
                        r_start <= 1'b1;
                        r_state <= S_C1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_C1: if (core_done) begin
                    r_h_in <= core_h; r_blk <= dsme_pkg::PAD_BLOCK;
                    r_start <= 1'b1; r_state <= S_C2;
                end
                S_C2: if (core_done) begin
                    r_h_in <= dsme_pkg::INIT_H; r_blk <= {r_digest, core_h};
                    r_start <= 1'b1; r_state <= S_C3;
                end
                S_C3: if (core_done) begin
                    r_h_in <= core_h; r_blk <= dsme_pkg::PAD_BLOCK;
                    r_start <= 1'b1; r_state <= S_C4;
                end
                S_C4: if (core_done) begin
                    r_digest <= core_h;
                    r_state <= S_PREP;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_outcome = r_job.outcome;
    assign o_digest  = r_digest;

endmodule

/* rtl/core/dsme_checker.sv */
// Port-level checker for the measurement extend block, bound to the top level.
`timescale 1ns / 1ps
module dsme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_outcome,
    input logic [63:0] o_digest_word_0,
    input logic        pready
);

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_outcome != 2'd3)) else $error("bad outcome code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word_0))
        else $error("result dropped under stall");

    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind dedup_sha256_measurement_extend dsme_checker u_dsme_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_outcome       (o_outcome),
    .o_digest_word_0 (o_digest_word_0),
    .pready          (pready)
);
